@@ design/ffst_pkg.sv @@
`default_nettype none
package ffst_pkg;

   localparam int FieldWidth = 20;
   localparam int CountWidth = 6;

   typedef logic [FieldWidth-1:0] field_type;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_ALLOC = 2'd1,
      STATUS_NOFIT = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_ALLOC = 1'b1
   } opcode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      field_type offset;
      field_type size;
   } span_type;

   // broadcast to every cell in the execute cycle
   typedef struct packed {
      logic       write;
      opcode_type op;
      field_type  offset;
      field_type  size;
      field_type  need;
   } cmd_type;

endpackage
`default_nettype wire

@@ design/first_fit_free_span_table_unit.sv @@
`default_nettype none
// A request word is registered when accepted; no new one is taken until its response
// word is registered. Execute is the compare-and-shift pass through the cell row (add
// and allocate alike), waiting while a response is untaken.
// Reset: synchronous, active high; clears the span count and handshake state.
// Table entries are not cleared.
module first_fit_free_span_table_unit
   import ffst_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [19:0] req_span_offset,
   input  wire logic [19:0] req_span_size,
   input  wire logic [19:0] req_need_size,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [19:0]      rsp_alloc_offset,
   output logic [5:0]       rsp_span_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   opcode_type    op_ff;
   field_type     offset_ff, size_ff, need_ff;
   logic [CW-1:0] count_ff, count_in;

   logic          rsp_valid_ff;
   status_type    status_ff;
   field_type     alloc_offset_ff;
   logic [5:0]    span_count_ff;

   logic          commit;
   logic          full;
   logic          found;
   status_type    status_in;
   logic [CW+5:0] count_ext;
   cmd_type       cmd;

   span_type  entries   [TABLE_DEPTH];
   logic      gts       [TABLE_DEPTH];
   logic      occupied  [TABLE_DEPTH];
   logic      seen      [TABLE_DEPTH+1];
   field_type hit_offset[TABLE_DEPTH+1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid)     state_in = ST_EXEC;
         ST_EXEC: if (!rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: commit    = !rsp_valid_ff;
         default: req_ready = 1'b0;
      endcase
   end

   assign full  = (count_ff == CW'(TABLE_DEPTH));
   assign found = seen[TABLE_DEPTH];

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_NOFIT;
      unique case (op_ff)
         OP_ADD: begin
            status_in = full ? STATUS_FULL : STATUS_ADDED;
            if (!full) count_in = count_ff + CW'(1);
         end
         OP_ALLOC: begin
            status_in = found ? STATUS_ALLOC : STATUS_NOFIT;
            if (found) count_in = count_ff - CW'(1);
         end
         default: status_in = STATUS_NOFIT;
      endcase
   end

   assign cmd.write  = commit && (status_in == STATUS_ADDED || status_in == STATUS_ALLOC);
   assign cmd.op     = op_ff;
   assign cmd.offset = offset_ff;
   assign cmd.size   = size_ff;
   assign cmd.need   = need_ff;

   assign seen[0]       = 1'b0;
   assign hit_offset[0] = '0;

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic     prev_gt;
         span_type prev_entry;
         span_type next_entry;

         assign occupied[i] = (CW'(i) < count_ff);

         if (i == 0) begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_entry = entries[0];
         end else begin : g_mid
            assign prev_gt    = gts[i-1];
            assign prev_entry = entries[i-1];
         end

         if (i == TABLE_DEPTH - 1) begin : g_last
            assign next_entry = entries[i];
         end else begin : g_inner
            assign next_entry = entries[i+1];
         end

         ffst_cell u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .occupied       (occupied[i]),
            .prev_gt        (prev_gt),
            .prev_entry     (prev_entry),
            .next_entry     (next_entry),
            .seen_in        (seen[i]),
            .hit_offset_in  (hit_offset[i]),
            .gt             (gts[i]),
            .entry          (entries[i]),
            .seen_out       (seen[i+1]),
            .hit_offset_out (hit_offset[i+1])
         );
      end
   endgenerate

   assign count_ext = {6'b0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff     <= opcode_type'(req_opcode);
         offset_ff <= req_span_offset;
         size_ff   <= req_span_size;
         need_ff   <= req_need_size;
      end
      if (commit) begin
         status_ff       <= status_in;
         alloc_offset_ff <= (status_in == STATUS_ALLOC) ? hit_offset[TABLE_DEPTH] : '0;
         span_count_ff   <= count_ext[5:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_alloc_offset = alloc_offset_ff;
   assign rsp_span_count   = span_count_ff;

endmodule
`default_nettype wire

@@ design/ffst_cell.sv @@
`default_nettype none
module ffst_cell
   import ffst_pkg::*;
(
   input  wire logic      clock,
   input  wire cmd_type   cmd,
   input  wire logic      occupied,
   input  wire logic      prev_gt,
   input  wire span_type  prev_entry,
   input  wire span_type  next_entry,
   input  wire logic      seen_in,
   input  wire field_type hit_offset_in,
   output logic           gt,
   output span_type       entry,
   output logic           seen_out,
   output field_type      hit_offset_out
);

   span_type entry_ff;
   span_type entry_in;
   logic     fit;

   assign entry = entry_ff;
   assign gt    = !occupied || (cmd.offset < entry_ff.offset);
   assign fit   = occupied && (entry_ff.size >= cmd.need);

   assign seen_out       = seen_in || fit;
   assign hit_offset_out = seen_in ? hit_offset_in : entry_ff.offset;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.write) begin
         unique case (cmd.op)
            OP_ALLOC: begin
               if (seen_out) entry_in = next_entry;
            end
            OP_ADD: begin
               if (gt) begin
                  if (prev_gt) entry_in = prev_entry;
                  else         entry_in = '{offset: cmd.offset, size: cmd.size};
               end
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

@@ dv/first_fit_free_span_table_unit_check.sv @@
`timescale 1ns / 100ps
module first_fit_free_span_table_unit_check
   import ffst_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_opcode,
   input  wire logic [19:0] req_span_offset,
   input  wire logic [19:0] req_span_size,
   input  wire logic [19:0] req_need_size,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [19:0] rsp_alloc_offset,
   input  wire logic [5:0]  rsp_span_count,
   output int               fault_count,
   output int               owed_count,
   output int               full_seen,
   output int               nofit_seen,
   output int               alloc_seen
);

   typedef struct packed {
      status_type            status;
      field_type             offset;
      logic [CountWidth-1:0] count;
   } outcome_type;

   field_type   held_offsets [TABLE_DEPTH];
   field_type   held_sizes [TABLE_DEPTH];
   int          held;
   outcome_type owed_outcomes [$];

   function automatic outcome_type predict_span_outcome(opcode_type op, field_type off,
                                                        field_type size, field_type need);
      outcome_type o;
      int          pos;
      o.offset = '0;
      if (op == OP_ADD) begin
         if (held >= TABLE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            pos = held;
            for (int k = 0; k < held; k++) begin
               if (off < held_offsets[k]) begin
                  pos = k;
                  break;
               end
            end
            for (int k = held; k > pos; k--) begin
               held_offsets[k] = held_offsets[k-1];
               held_sizes[k]   = held_sizes[k-1];
            end
            held_offsets[pos] = off;
            held_sizes[pos]   = size;
            held++;
            o.status = STATUS_ADDED;
         end
      end else begin
         pos = held;
         for (int k = 0; k < held; k++) begin
            if (held_sizes[k] >= need) begin
               pos = k;
               break;
            end
         end
         if (pos >= held) begin
            o.status = STATUS_NOFIT;
         end else begin
            o.offset = held_offsets[pos];
            for (int k = pos; k + 1 < held; k++) begin
               held_offsets[k] = held_offsets[k+1];
               held_sizes[k]   = held_sizes[k+1];
            end
            held--;
            o.status = STATUS_ALLOC;
         end
      end
      o.count = CountWidth'(held);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         held = 0;
         owed_outcomes.delete();
      end else begin
         // responses first so a word cannot match a request taken in the same edge
         if (rsp_valid && rsp_ready) begin
            got.status = status_type'(rsp_status);
            got.offset = rsp_alloc_offset;
            got.count  = rsp_span_count;
            if (owed_outcomes.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected response word status %0d offset %h count %0d",
                        $time, got.status, got.offset, got.count);
            end else begin
               want = owed_outcomes.pop_front();
               case (want.status)
                  STATUS_FULL:  full_seen++;
                  STATUS_NOFIT: nofit_seen++;
                  STATUS_ALLOC: alloc_seen++;
                  default: ;
               endcase
               if (got.status != want.status) begin
                  fault_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               end
               if (got.offset != want.offset) begin
                  fault_count++;
                  $display("%0t: alloc_offset expected %h actual %h",
                           $time, want.offset, got.offset);
               end
               if (got.count != want.count) begin
                  fault_count++;
                  $display("%0t: span_count expected %0d actual %0d",
                           $time, want.count, got.count);
               end
            end
         end
         if (req_valid && req_ready) begin
            owed_outcomes.push_back(predict_span_outcome(opcode_type'(req_opcode),
               req_span_offset, req_span_size, req_need_size));
         end
      end
      owed_count = owed_outcomes.size();
   end

endmodule

@@ dv/first_fit_free_span_table_unit_test.sv @@
`timescale 1ns / 100ps
module first_fit_free_span_table_unit_test;
   import ffst_pkg::*;

   localparam int QuietLimit = 4000;
   localparam int RandomWords = 1200;
   localparam int CalmTail = 150;
   localparam field_type FieldMax = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [19:0] req_span_offset = '0;
   logic [19:0] req_span_size = '0;
   logic [19:0] req_need_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [19:0] rsp_alloc_offset;
   logic [5:0]  rsp_span_count;

   int   fault_count;
   int   owed_count;
   int   full_seen;
   int   nofit_seen;
   int   alloc_seen;
   int   quiet_cycles = 0;
   int   words_sent = 0;
   bit   idling = 1'b1;

   field_type offset_pool [8] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h00400,
                                  20'h12345, 20'h7FFFF, 20'h00001, 20'h40000};

   first_fit_free_span_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_span_offset(req_span_offset), .req_span_size(req_span_size),
      .req_need_size(req_need_size),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_alloc_offset(rsp_alloc_offset), .rsp_span_count(rsp_span_count)
   );

   first_fit_free_span_table_unit_check check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_span_offset(req_span_offset), .req_span_size(req_span_size),
      .req_need_size(req_need_size),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_alloc_offset(rsp_alloc_offset), .rsp_span_count(rsp_span_count),
      .fault_count(fault_count), .owed_count(owed_count), .full_seen(full_seen),
      .nofit_seen(nofit_seen), .alloc_seen(alloc_seen)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic send_word(opcode_type op, field_type off, field_type size, field_type need);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_span_offset <= off;
      req_span_size   <= size;
      req_need_size   <= need;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   function automatic field_type pick_size();
      case ($urandom_range(0, 5))
         0, 1:    return field_type'($urandom_range(0, 64));
         2:       return '0;
         3:       return FieldMax;
         default: return field_type'($urandom);
      endcase
   endfunction

   function automatic field_type pick_offset();
      if ($urandom_range(0, 3) == 0) return offset_pool[$urandom_range(0, 7)];
      return field_type'($urandom);
   endfunction

   // receiver back-pressure in bursts
   initial begin
      @(negedge reset);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (idling) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("FAIL first_fit_free_span_table_unit");
            $finish;
         end
      end
   end

   initial begin
      int phase_len;
      int add_pct;
      int done;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then extremes, equal offsets and zero need
      send_word(OP_ALLOC, 20'h0, 20'h0, 20'h0);
      send_word(OP_ALLOC, FieldMax, FieldMax, FieldMax);
      send_word(OP_ADD, 20'h80000, 20'h00100, FieldMax);
      send_word(OP_ADD, 20'h00000, 20'h00000, 20'h0);
      send_word(OP_ADD, FieldMax, FieldMax, 20'h0);
      send_word(OP_ADD, 20'h80000, 20'h00200, 20'h55555);
      send_word(OP_ADD, 20'h80000, 20'h00300, 20'hAAAAA);
      send_word(OP_ALLOC, 20'h55555, 20'hAAAAA, 20'h00200);
      send_word(OP_ALLOC, FieldMax, FieldMax, 20'h00000);
      send_word(OP_ALLOC, 20'h0, 20'h0, FieldMax);
      send_word(OP_ALLOC, 20'h0, 20'h0, FieldMax);
      send_word(OP_ADD, 20'h12345, 20'h54321, 20'h12345);
      send_word(OP_ADD, 20'h00001, 20'h00001, 20'h0);
      send_word(OP_ALLOC, 20'h0, 20'h0, 20'h00002);
      send_word(OP_ALLOC, 20'h0, 20'h0, 20'h00001);
      for (int i = 0; i < 4; i++) send_word(OP_ALLOC, 20'h0, 20'h0, 20'h0);

      // phases lean towards filling or draining so full and empty are both reached
      done = 0;
      while (done < RandomWords) begin
         phase_len = $urandom_range(40, 90);
         case ($urandom_range(0, 2))
            0:       add_pct = 85;
            1:       add_pct = 50;
            default: add_pct = 20;
         endcase
         for (int i = 0; i < phase_len && done < RandomWords; i++) begin
            if (done >= RandomWords - CalmTail) idling = 1'b0;
            if ($urandom_range(0, 99) < add_pct) begin
               send_word(OP_ADD, pick_offset(), pick_size(), field_type'($urandom));
            end else begin
               send_word(OP_ALLOC, field_type'($urandom), field_type'($urandom), pick_size());
            end
            done++;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d request words: %0d allocations, %0d no-fit, %0d table-full.",
               words_sent, alloc_seen, nofit_seen, full_seen);
      if (fault_count == 0) begin
         $display("PASS first_fit_free_span_table_unit");
      end else begin
         $display("FAIL first_fit_free_span_table_unit");
      end
      $finish;
   end

endmodule
